// ===== design/g_peb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package g_peb_pkg;

  localparam logic [7:0]  DleByte    = 8'h10;
  localparam logic [15:0] CheckMagic = 16'hAAAA;
  localparam logic [15:0] SumInit    = 16'hFFFF;
  localparam logic [3:0]  NoDataK    = 4'd9;
  localparam logic [3:0]  MaxCode    = 4'd8;
  localparam logic [12:0] SegBase    = 13'd16;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    POS_DLE  = 3'd0,
    POS_K    = 3'd1,
    POS_C0   = 3'd2,
    POS_C1   = 3'd3,
    POS_CTRL = 3'd4,
    POS_XOR  = 3'd5
  } pos_e;

  typedef struct packed {
    logic       command;
    logic [1:0] packet_type;
    logic [2:0] first_field;
    logic [2:0] second_field;
    logic [3:0] segment_code;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  k;
    logic [15:0] sum;
    logic [7:0]  ctrl;
  } env_t;

endpackage

`default_nettype wire

// ===== design/g_peb_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface g_peb_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] packet_type;
  logic [2:0] first_field;
  logic [2:0] second_field;
  logic [3:0] segment_code;
  logic [7:0] data_byte;

  modport source (
    output valid, command, packet_type, first_field, second_field, segment_code, data_byte,
    input  ready
  );

  modport sink (
    input  valid, command, packet_type, first_field, second_field, segment_code, data_byte,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/g_peb_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface g_peb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       last_of_envelope;

  modport source (
    output valid, wire_byte, last_of_envelope,
    input  ready
  );

  modport sink (
    input  valid, wire_byte, last_of_envelope,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/g_packet_envelope_builder.sv =====
// path: a closing item's envelope is registered as pending, then loaded to the output
// throughput: one item per cycle while no envelope waits behind the one on the output
// an envelope occupies the output for six words; one more is held, then input stalls
// the checksum step (rotate, add, add, compare) for one data word is combinational
// reset: checksum state to its initial value, no packet open, no words pending
`timescale 1ns / 1ps
`default_nettype none

module g_packet_envelope_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  g_peb_in_if.sink           in_i,
  g_peb_out_if.source        out_o
);

  logic             accept;
  logic             in_ready;
  logic             push;
  g_peb_pkg::item_t item;
  g_peb_pkg::env_t  env;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  assign item = '{
    command:      in_i.command,
    packet_type:  in_i.packet_type,
    first_field:  in_i.first_field,
    second_field: in_i.second_field,
    segment_code: in_i.segment_code,
    data_byte:    in_i.data_byte
  };

  g_peb_csum u_csum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .push_o   (push),
    .env_o    (env)
  );

  g_peb_env u_env (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .env_i       (env),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .wire_byte_o (out_o.wire_byte),
    .last_o      (out_o.last_of_envelope)
  );

endmodule

`default_nettype wire

// ===== design/g_peb_csum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module g_peb_csum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  g_peb_pkg::item_t item_i,
  output logic             push_o,
  output g_peb_pkg::env_t  env_o
);

  logic [15:0] rs_q, rs_d;
  logic [15:0] rt_q, rt_d;
  logic [12:0] br_q, br_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [3:0]  k_q, k_d;
  logic        open_q, open_d;

  logic [15:0] rot;
  logic [15:0] add;
  logic [15:0] rt_sum;
  logic [15:0] rs_new;
  logic [12:0] br_dec;
  logic [7:0]  ctrl_new;

  // g checksum step
  assign rot      = {rs_q[14:0], rs_q[15]};
  assign add      = rot + {8'h00, item_i.data_byte};
  assign rt_sum   = rt_q + (add ^ {3'b000, br_q});
  assign rs_new   = (add <= rot) ? (add ^ rt_sum) : add;
  assign br_dec   = br_q - 13'd1;
  assign ctrl_new = {item_i.packet_type, item_i.first_field, item_i.second_field};

  always_comb begin
    rs_d   = rs_q;
    rt_d   = rt_q;
    br_d   = br_q;
    ctrl_d = ctrl_q;
    k_d    = k_q;
    open_d = open_q;
    push_o = 1'b0;
    env_o  = '{k: k_q, sum: rs_q, ctrl: ctrl_q};
    if (accept_i) begin
      if (item_i.command == g_peb_pkg::CMD_START) begin
        if (item_i.segment_code <= g_peb_pkg::MaxCode) begin
          ctrl_d = ctrl_new;
          rs_d   = g_peb_pkg::SumInit;
          rt_d   = 16'h0000;
          if (item_i.segment_code == 4'd0) begin
            open_d = 1'b0;
            br_d   = 13'd0;
            k_d    = g_peb_pkg::NoDataK;
            push_o = 1'b1;
            env_o  = '{k: g_peb_pkg::NoDataK, sum: 16'h0000, ctrl: ctrl_new};
          end else begin
            k_d    = item_i.segment_code;
            br_d   = g_peb_pkg::SegBase << item_i.segment_code;
            open_d = 1'b1;
          end
        end
      end else if (open_q) begin
        rs_d = rs_new;
        rt_d = rt_sum;
        br_d = br_dec;
        if (br_dec == 13'd0) begin
          open_d = 1'b0;
          push_o = 1'b1;
          env_o  = '{k: k_q, sum: rs_new, ctrl: ctrl_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q   <= g_peb_pkg::SumInit;
      rt_q   <= 16'h0000;
      br_q   <= 13'd0;
      ctrl_q <= 8'h00;
      k_q    <= g_peb_pkg::NoDataK;
      open_q <= 1'b0;
    end else begin
      rs_q   <= rs_d;
      rt_q   <= rt_d;
      br_q   <= br_d;
      ctrl_q <= ctrl_d;
      k_q    <= k_d;
      open_q <= open_d;
    end
  end

`ifndef SYNTH
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == (br_q != 13'd0))
    else $error("open flag and byte count disagree");

  a_open_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (k_q != g_peb_pkg::NoDataK && k_q != 4'd0))
    else $error("open packet with no-data size code");

  a_push_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> !open_q && rs_q == g_peb_pkg::SumInit || !open_q)
    else $error("envelope pushed while packet stays open");
`endif

endmodule

`default_nettype wire

// ===== design/g_peb_env.sv =====
`timescale 1ns / 1ps
`default_nettype none

module g_peb_env (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  g_peb_pkg::env_t env_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      wire_byte_o,
  output logic            last_o
);

  g_peb_pkg::env_t pend_q, pend_d;
  logic            pend_vld_q, pend_vld_d;

  logic            drain_q, drain_d;
  g_peb_pkg::pos_e pos_q, pos_d, pos_next;
  logic [3:0]      k_q, k_d;
  logic [15:0]     check_q, check_d;
  logic [7:0]      ctrl_q, ctrl_d;

  logic            out_fire;
  logic            load;
  logic [7:0]      xor_byte;

  assign out_fire   = drain_q && out_ready_i;
  assign load       = pend_vld_q && (!drain_q || (out_fire && pos_q == g_peb_pkg::POS_XOR));
  assign in_ready_o = !pend_vld_q || load;

  always_comb begin
    case (pos_q)
      g_peb_pkg::POS_DLE:  pos_next = g_peb_pkg::POS_K;
      g_peb_pkg::POS_K:    pos_next = g_peb_pkg::POS_C0;
      g_peb_pkg::POS_C0:   pos_next = g_peb_pkg::POS_C1;
      g_peb_pkg::POS_C1:   pos_next = g_peb_pkg::POS_CTRL;
      g_peb_pkg::POS_CTRL: pos_next = g_peb_pkg::POS_XOR;
      default:             pos_next = g_peb_pkg::POS_DLE;
    endcase
  end

  always_comb begin
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    drain_d    = drain_q;
    pos_d      = pos_q;
    k_d        = k_q;
    check_d    = check_q;
    ctrl_d     = ctrl_q;
    if (push_i) begin
      pend_d     = env_i;
      pend_vld_d = 1'b1;
    end else if (load) begin
      pend_vld_d = 1'b0;
    end
    if (load) begin
      drain_d = 1'b1;
      pos_d   = g_peb_pkg::POS_DLE;
      k_d     = pend_q.k;
      check_d = g_peb_pkg::CheckMagic - (pend_q.sum ^ {8'h00, pend_q.ctrl});
      ctrl_d  = pend_q.ctrl;
    end else if (out_fire) begin
      if (pos_q == g_peb_pkg::POS_XOR) begin
        drain_d = 1'b0;
      end
      pos_d = pos_next;
    end
  end

  assign xor_byte = {4'h0, k_q} ^ check_q[7:0] ^ check_q[15:8] ^ ctrl_q;

  always_comb begin
    case (pos_q)
      g_peb_pkg::POS_DLE:  wire_byte_o = g_peb_pkg::DleByte;
      g_peb_pkg::POS_K:    wire_byte_o = {4'h0, k_q};
      g_peb_pkg::POS_C0:   wire_byte_o = check_q[7:0];
      g_peb_pkg::POS_C1:   wire_byte_o = check_q[15:8];
      g_peb_pkg::POS_CTRL: wire_byte_o = ctrl_q;
      g_peb_pkg::POS_XOR:  wire_byte_o = xor_byte;
      default:             wire_byte_o = g_peb_pkg::DleByte;
    endcase
  end

  assign out_valid_o = drain_q;
  assign last_o      = (pos_q == g_peb_pkg::POS_XOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      drain_q    <= 1'b0;
      pos_q      <= g_peb_pkg::POS_DLE;
    end else begin
      pend_vld_q <= pend_vld_d;
      drain_q    <= drain_d;
      pos_q      <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    k_q     <= k_d;
    check_q <= check_d;
    ctrl_q  <= ctrl_d;
  end

`ifndef SYNTH
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !pend_vld_q || load)
    else $error("envelope pushed over a pending one");

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q && !load |=> pend_vld_q)
    else $error("pending envelope dropped");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q && out_ready_i && pos_q == g_peb_pkg::POS_DLE |=> pos_q == g_peb_pkg::POS_K)
    else $error("envelope position did not advance");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> drain_q && pos_q == g_peb_pkg::POS_DLE)
    else $error("envelope load did not start at the first word");
`endif

endmodule

`default_nettype wire
